@@ rtl/lmbs_pkg.sv @@
// Shared types and codes for the LED matrix bit-plane scan core.
`default_nettype none

package lmbs_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  pixel_column;
        logic [3:0]  pixel_row;
        logic [11:0] pixel_color;
    } item_t;

    typedef struct packed {
        logic [7:0] upper_bits;
        logic [7:0] lower_bits;
        logic [1:0] row_address;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        CMD_EMIT,
        CMD_WRITE,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  scan_row;
        logic [1:0]  plane;
        logic [5:0]  pixel_column;
        logic [3:0]  pixel_row;
        logic [11:0] pixel_color;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_EMIT,
        BK_WRITE
    } bk_state_t;

endpackage

`default_nettype wire

@@ rtl/lmbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 576
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/lmbs_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
`default_nettype none

module lmbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lmbs_front.sv @@
// Front end: accepts transactions, runs the plane scheduler and queues commands.
`default_nettype none

module lmbs_front #(
    parameter int PLANES = 3
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire lmbs_pkg::item_t item,
    input  wire logic           store_init,
    input  wire logic           cmd_full,
    output logic                cmd_push,
    output lmbs_pkg::cmd_t      cmd
);

    import lmbs_pkg::*;

    localparam int TCW = PLANES;

    logic [TCW-1:0] tick_count_reg, tick_count_next;
    logic [1:0]     plane_index_reg, plane_index_next;
    logic [1:0]     scan_row_reg, scan_row_next;
    logic [TCW-1:0] tick_inc;
    logic [TCW-1:0] tick_limit;
    logic [2:0]     plane_inc;
    logic           accept;

    assign item_ready = !cmd_full && !store_init;
    assign accept     = item_valid && item_ready;
    assign tick_inc   = tick_count_reg + 1'b1;
    assign tick_limit = TCW'(1) << plane_index_reg;
    assign plane_inc  = {1'b0, plane_index_reg} + 3'd1;

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        plane_index_next = plane_index_reg;
        scan_row_next    = scan_row_reg;
        cmd_push         = 1'b0;
        cmd.kind         = CMD_EMIT;
        cmd.scan_row     = scan_row_reg;
        cmd.plane        = plane_index_reg;
        cmd.pixel_column = item.pixel_column;
        cmd.pixel_row    = item.pixel_row;
        cmd.pixel_color  = item.pixel_color;
        if (accept)
        begin
            case (item.op)
                OP_TICK:
                begin
                    cmd_push        = (tick_count_reg == '0);
                    tick_count_next = tick_inc;
                    if (tick_inc >= tick_limit)
                    begin
                        tick_count_next = '0;
                        if (plane_inc >= 3'(PLANES))
                        begin
                            plane_index_next = '0;
                            scan_row_next    = scan_row_reg + 1'b1;
                        end
                        else
                        begin
                            plane_index_next = plane_inc[1:0];
                        end
                    end
                end
                OP_WRITE:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_WRITE;
                end
                OP_CLEAR:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_CLEAR;
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            plane_index_reg <= '0;
            scan_row_reg    <= '0;
        end
        else
        begin
            tick_count_reg  <= tick_count_next;
            plane_index_reg <= plane_index_next;
            scan_row_reg    <= scan_row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lmbs_back.sv @@
// Back end: frame store banks, pixel read-modify-write, clear sweep and plane readout.
`default_nettype none

module lmbs_back #(
    parameter int PANEL_WIDTH = 64,
    parameter int PLANES      = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lmbs_pkg::cmd_t   cmd,
    input  wire logic             cmd_empty,
    output logic                  cmd_pop,
    output logic                  store_init,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output lmbs_pkg::result_t     result
);

    import lmbs_pkg::*;

    localparam int PB    = (PANEL_WIDTH / 8) * 6;
    localparam int PAGE  = PLANES * PB;
    localparam int HALF  = 4 * PAGE;
    localparam int STORE = 2 * HALF;
    localparam int BW    = $clog2(HALF);
    localparam int FW    = $clog2(STORE) + 1;
    localparam int KW    = $clog2(PB);
    localparam int OCW   = $clog2(OUT_DEPTH + 1);

    bk_state_t      state_reg, state_next;
    logic           boot_reg, boot_next;
    logic [BW-1:0]  clr_addr_reg, clr_addr_next;
    logic [BW-1:0]  emit_addr_reg, emit_addr_next;
    logic [KW-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [1:0]     emit_row_reg, emit_row_next;
    logic [FW-1:0]  wr_base_reg, wr_base_next;
    logic [1:0]     wr_g_reg, wr_g_next;
    logic [1:0]     wr_c_reg, wr_c_next;
    logic [11:0]    wr_color_reg, wr_color_next;
    logic [2:0]     wr_pos_reg, wr_pos_next;
    logic           pend_valid_reg, pend_valid_next;
    logic           pend_bank_reg, pend_bank_next;
    logic [BW-1:0]  pend_addr_reg, pend_addr_next;
    logic           pend_set_reg, pend_set_next;
    logic [2:0]     pend_pos_reg, pend_pos_next;
    logic           rd_valid_reg, rd_valid_next;
    logic           rd_last_reg, rd_last_next;
    logic [1:0]     rd_row_reg, rd_row_next;

    logic [FW-1:0]  flat;
    logic           flat_hi;
    logic           flat_ok;
    logic [BW-1:0]  flat_local;
    logic [3:0]     color_grp;
    logic [2:0]     page;
    logic [BW-1:0]  raddr;
    logic           we0, we1;
    logic [BW-1:0]  waddr;
    logic [7:0]     wdata;
    logic [7:0]     rdata0, rdata1;
    logic [7:0]     old_byte, bit_mask;
    logic           out_full, out_empty, out_pop;
    logic [OCW-1:0] out_count;
    logic [OCW:0]   out_credit;
    logic           can_issue;
    result_t        out_data;
    logic [$bits(result_t)-1:0] out_raw;

    assign store_init = boot_reg;

    assign flat       = wr_base_reg + FW'({wr_g_reg, 1'b0});
    assign flat_hi    = (flat >= FW'(HALF));
    assign flat_ok    = (flat < FW'(STORE));
    assign flat_local = flat_hi ? BW'(flat - FW'(HALF)) : BW'(flat);
    assign page       = {cmd.pixel_row[3], cmd.pixel_row[1:0]};

    always_comb
    begin
        case (wr_g_reg)
            2'd0:    color_grp = wr_color_reg[3:0];
            2'd1:    color_grp = wr_color_reg[7:4];
            default: color_grp = wr_color_reg[11:8];
        endcase
    end

    // Credit for the result queue counts reads still in flight.
    assign out_pop    = result_ready && !out_empty;
    assign out_credit = (OCW+1)'(out_count) + (OCW+1)'(rd_valid_reg) - (OCW+1)'(out_pop);
    assign can_issue  = (out_credit < (OCW+1)'(OUT_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        boot_next       = boot_reg;
        clr_addr_next   = clr_addr_reg;
        emit_addr_next  = emit_addr_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_row_next   = emit_row_reg;
        wr_base_next    = wr_base_reg;
        wr_g_next       = wr_g_reg;
        wr_c_next       = wr_c_reg;
        wr_color_next   = wr_color_reg;
        wr_pos_next     = wr_pos_reg;
        pend_valid_next = 1'b0;
        pend_bank_next  = pend_bank_reg;
        pend_addr_next  = pend_addr_reg;
        pend_set_next   = pend_set_reg;
        pend_pos_next   = pend_pos_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = rd_last_reg;
        rd_row_next     = rd_row_reg;
        cmd_pop         = 1'b0;
        raddr           = flat_local;

        case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_EMIT:
                        begin
                            state_next     = BK_EMIT;
                            emit_addr_next = BW'(cmd.scan_row) * BW'(PAGE)
                                           + BW'(cmd.plane) * BW'(PB);
                            emit_cnt_next  = '0;
                            emit_row_next  = cmd.scan_row;
                        end
                        CMD_WRITE:
                        begin
                            if (32'(cmd.pixel_column) < PANEL_WIDTH)
                            begin
                                state_next    = BK_WRITE;
                                wr_base_next  = FW'(page) * FW'(PAGE)
                                              + FW'(cmd.pixel_column[5:3]) * FW'(6)
                                              + FW'(cmd.pixel_row[2]);
                                wr_g_next     = '0;
                                wr_c_next     = '0;
                                wr_color_next = cmd.pixel_color;
                                wr_pos_next   = cmd.pixel_column[2:0];
                            end
                        end
                        CMD_CLEAR:
                        begin
                            state_next    = BK_CLEAR;
                            clr_addr_next = '0;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == BW'(HALF - 1))
                begin
                    state_next = BK_IDLE;
                    boot_next  = 1'b0;
                end
            end

            BK_EMIT:
            begin
                raddr = emit_addr_reg;
                if (can_issue)
                begin
                    rd_valid_next  = 1'b1;
                    rd_last_next   = (emit_cnt_reg == KW'(PB - 1));
                    rd_row_next    = emit_row_reg;
                    emit_addr_next = emit_addr_reg + 1'b1;
                    emit_cnt_next  = emit_cnt_reg + 1'b1;
                    if (emit_cnt_reg == KW'(PB - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end

            BK_WRITE:
            begin
                // read this byte now, write it back modified next cycle
                pend_valid_next = flat_ok;
                pend_bank_next  = flat_hi;
                pend_addr_next  = flat_local;
                pend_set_next   = color_grp[wr_c_reg];
                pend_pos_next   = wr_pos_reg;
                if (wr_g_reg == 2'd2)
                begin
                    wr_g_next    = '0;
                    wr_c_next    = wr_c_reg + 1'b1;
                    wr_base_next = wr_base_reg + FW'(PB);
                    if (wr_c_reg == 2'(PLANES - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    wr_g_next = wr_g_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign old_byte = pend_bank_reg ? rdata1 : rdata0;
    assign bit_mask = 8'd1 << pend_pos_reg;

    always_comb
    begin
        if (state_reg == BK_CLEAR)
        begin
            we0   = 1'b1;
            we1   = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we0   = pend_valid_reg && !pend_bank_reg;
            we1   = pend_valid_reg && pend_bank_reg;
            waddr = pend_addr_reg;
            wdata = pend_set_reg ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
        end
    end

    lmbs_ram #(
        .WIDTH (8),
        .DEPTH (HALF)
    ) u_upper_bank (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    lmbs_ram #(
        .WIDTH (8),
        .DEPTH (HALF)
    ) u_lower_bank (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    always_comb
    begin
        out_data.upper_bits  = rdata0;
        out_data.lower_bits  = rdata1;
        out_data.row_address = rd_last_reg ? rd_row_reg : 2'd0;
        out_data.last        = rd_last_reg;
    end

    lmbs_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_valid_reg),
        .push_data (out_data),
        .pop       (out_pop),
        .pop_data  (out_raw),
        .full      (out_full),
        .empty     (out_empty),
        .count     (out_count)
    );

    assign result_valid = !out_empty && !(out_full && 1'b0);
    assign result       = result_t'(out_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            boot_reg       <= 1'b1;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            boot_reg       <= boot_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            rd_valid_reg   <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        emit_addr_reg <= emit_addr_next;
        emit_cnt_reg  <= emit_cnt_next;
        emit_row_reg  <= emit_row_next;
        wr_base_reg   <= wr_base_next;
        wr_g_reg      <= wr_g_next;
        wr_c_reg      <= wr_c_next;
        wr_color_reg  <= wr_color_next;
        wr_pos_reg    <= wr_pos_next;
        pend_bank_reg <= pend_bank_next;
        pend_addr_reg <= pend_addr_next;
        pend_set_reg  <= pend_set_next;
        pend_pos_reg  <= pend_pos_next;
        rd_last_reg   <= rd_last_next;
        rd_row_reg    <= rd_row_next;
    end

endmodule

`default_nettype wire

@@ rtl/led_matrix_bitplane_scan_core.sv @@
// Top level of the LED matrix bit-plane scan core.
// Usage:
//   item channel (item_valid/item_ready/item): refresh tick, pixel write or store clear.
//   result channel (result_valid/result_ready/result): byte pairs for the upper and
//   lower data lines; the final pair of a plane carries last and the row address.
// A refresh tick on the first tick of a plane produces PANEL_WIDTH/8*6 transactions
// (48 by default) at one per cycle while the result queue has room, read from two
// frame-store banks in parallel; the first pair passes through the command queue,
// the emit state, the registered bank read and the result queue. Other ticks
// produce nothing. A pixel write is a read-modify-write of three bytes per plane
// on one port; a clear sweeps 4*PLANES*PANEL_WIDTH/8*6 addresses in each bank (576 by default).
// A two-entry command queue sits between the front end and the store, so items are
// taken while the store is still busy, until the queue fills.
// At reset the scheduler returns to plane 0 of row 0 and the store is swept to zero:
// item_ready stays low until the sweep ends. When the receiver stalls, readout
// pauses behind a two-entry result queue and no transaction is lost.
`default_nettype none

module led_matrix_bitplane_scan_core #(
    parameter int PANEL_WIDTH = 64,
    parameter int PLANES      = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire lmbs_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output lmbs_pkg::result_t      result
);

    import lmbs_pkg::*;

    logic                      store_init;
    logic                      cmd_push, cmd_pop;
    logic                      cmd_full, cmd_empty;
    cmd_t                      cmd_in;
    logic [$bits(cmd_t)-1:0]   cmd_raw;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    cmd_t                      cmd_head;

    lmbs_front #(
        .PLANES (PLANES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .store_init (store_init),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    lmbs_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_raw),
        .full      (cmd_full),
        .empty     (cmd_empty),
        .count     (cmd_count)
    );

    assign cmd_head = cmd_t'(cmd_raw);

    lmbs_back #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PLANES      (PLANES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_head),
        .cmd_empty    (cmd_empty || (cmd_count == '0)),
        .cmd_pop      (cmd_pop),
        .store_init   (store_init),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ dv/led_matrix_bitplane_scan_core_test.sv @@
// Self-checking testbench for the LED matrix bit-plane scan core.
`timescale 1ns / 1ps

import lmbs_pkg::*;

class scan_scoreboard;
    localparam int PLANE_BYTES = 48;
    localparam int PAGE_BYTES  = 144;
    localparam int STORE_BYTES = 1152;
    localparam int NUM_PLANES  = 3;

    logic [7:0] frame [0:STORE_BYTES-1];
    logic [2:0] ticks_in_plane;
    logic [1:0] plane;
    logic [1:0] row;
    result_t    pending_pairs[$];
    int         errors;
    int         pairs_checked;
    int         n_ticks;
    int         n_writes;
    int         n_clears;
    int         n_ignored;

    function new();
        for (int i = 0; i < STORE_BYTES; i++)
            frame[i] = 8'h00;
        ticks_in_plane = '0;
        plane          = '0;
        row            = '0;
        errors         = 0;
        pairs_checked  = 0;
        n_ticks        = 0;
        n_writes       = 0;
        n_clears       = 0;
        n_ignored      = 0;
    endfunction

    function void set_bit(int idx, logic [2:0] pos, logic on);
        frame[idx][pos] = on;
    endfunction

    function void note_item(item_t it);
        int page;
        int base;
        int at;
        int up;
        int lo;
        result_t r;
        case (it.op)
            OP_WRITE:
            begin
                n_writes++;
                page = int'(it.pixel_row[1:0]) + (it.pixel_row[3] ? 4 : 0);
                base = page * PAGE_BYTES + int'(it.pixel_column[5:3]) * 6
                       + int'(it.pixel_row[2]);
                for (int c = 0; c < NUM_PLANES; c++)
                begin
                    at = base + c * PLANE_BYTES;
                    set_bit(at,     it.pixel_column[2:0], it.pixel_color[c]);
                    set_bit(at + 2, it.pixel_column[2:0], it.pixel_color[c + 4]);
                    set_bit(at + 4, it.pixel_column[2:0], it.pixel_color[c + 8]);
                end
            end
            OP_CLEAR:
            begin
                n_clears++;
                for (int i = 0; i < STORE_BYTES; i++)
                    frame[i] = 8'h00;
            end
            OP_TICK:
            begin
                n_ticks++;
                if (ticks_in_plane == 0)
                begin
                    up = int'(row) * PAGE_BYTES + int'(plane) * PLANE_BYTES;
                    lo = (int'(row) + 4) * PAGE_BYTES + int'(plane) * PLANE_BYTES;
                    for (int k = 0; k < PLANE_BYTES; k++)
                    begin
                        r.upper_bits  = frame[up + k];
                        r.lower_bits  = frame[lo + k];
                        r.last        = (k == PLANE_BYTES - 1);
                        r.row_address = r.last ? row : 2'd0;
                        pending_pairs.push_back(r);
                    end
                end
                ticks_in_plane++;
                if (ticks_in_plane >= (3'd1 << plane))
                begin
                    ticks_in_plane = '0;
                    if (plane == NUM_PLANES - 1)
                    begin
                        plane = '0;
                        row   = row + 2'd1;
                    end
                    else
                        plane = plane + 2'd1;
                end
            end
            default:
                n_ignored++;
        endcase
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending_pairs.size() == 0)
        begin
            $display("%0t: unexpected transaction %h", $time, got);
            errors++;
            return;
        end
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (got.upper_bits !== want.upper_bits)
        begin
            $display("%0t: upper_bits expected %h actual %h", $time,
                     want.upper_bits, got.upper_bits);
            errors++;
        end
        if (got.lower_bits !== want.lower_bits)
        begin
            $display("%0t: lower_bits expected %h actual %h", $time,
                     want.lower_bits, got.lower_bits);
            errors++;
        end
        if (got.row_address !== want.row_address)
        begin
            $display("%0t: row_address expected %0d actual %0d", $time,
                     want.row_address, got.row_address);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_pairs.size();
    endfunction
endclass

module led_matrix_bitplane_scan_core_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 145;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    scan_scoreboard sb;
    bit             calm;
    int             quiet_cycles;

    led_matrix_bitplane_scan_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(item_t it);
        item       = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_op(logic [1:0] op, logic [5:0] col, logic [3:0] row,
                           logic [11:0] color);
        item_t it;
        it.op           = op;
        it.pixel_column = col;
        it.pixel_row    = row;
        it.pixel_color  = color;
        send_item(it);
    endtask

    // receiver
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int          counted;
        int          pick;
        logic [1:0]  op;
        sb         = new();
        calm       = 1'b0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed
        send_op(OP_TICK,  6'd0,  4'd0,  12'h000);
        send_op(OP_WRITE, 6'd0,  4'd0,  12'hFFF);
        send_op(OP_WRITE, 6'd63, 4'd15, 12'hFFF);
        send_op(OP_WRITE, 6'd7,  4'd4,  12'h777);
        send_op(OP_WRITE, 6'd8,  4'd8,  12'h888);
        send_op(OP_WRITE, 6'd56, 4'd12, 12'h5A3);
        send_op(OP_UNUSED, 6'd63, 4'd15, 12'hFFF);
        for (int i = 0; i < 7; i++)
            send_op(OP_TICK, 6'd0, 4'd0, 12'h000);
        send_op(OP_WRITE, 6'd0,  4'd0,  12'h000);
        send_op(OP_CLEAR, 6'd0,  4'd0,  12'h000);
        send_op(OP_WRITE, 6'd33, 4'd3,  12'h124);
        for (int i = 0; i < 4; i++)
            send_op(OP_TICK, 6'd0, 4'd0, 12'h000);

        // random
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= 80 && counted < 120);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_TICK;
            else if (pick < 92)
                op = OP_WRITE;
            else if (pick < 96)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;
            send_op(op, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                    12'($urandom_range(0, 4095)));
            if (op != OP_UNUSED)
                counted++;
        end
        calm       = 1'b0;
        item_valid = 1'b0;

        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);

        $display("covered %0d ticks, %0d pixel writes, %0d clears, %0d ignored items",
                 sb.n_ticks, sb.n_writes, sb.n_clears, sb.n_ignored);
        $display("checked %0d byte-pair transactions, %0d mismatches",
                 sb.pairs_checked, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
